// ----- hdl/dtx_pkg.sv -----
package dtx_pkg;

  // Shared multiplier operand width (signed), product is twice as wide
  localparam int MUL_W = 33;

  // Fixed-point constants
  localparam logic [25:0] LOG2_10_Q24 = 26'd55732705;
  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;
  localparam logic [31:0] EPS_Q64     = 32'd1844674407;
  localparam logic [31:0] INV_WHITE_ONE = 32'd16777216;
  localparam int EXP_BITS = 20;
  localparam int LOG_BITS = 20;

  // Opcodes
  typedef enum logic [1:0] {
    OP_LOAD_NEG  = 2'd0,
    OP_LOAD_PRT  = 2'd1,
    OP_CONV_NEG  = 2'd2,
    OP_CONV_PRT  = 2'd3
  } opcode_t;

  // Register indexes
  typedef enum logic [2:0] {
    REG_NEG_ENTRIES   = 3'd0,
    REG_PRT_ENTRIES   = 3'd1,
    REG_NEG_BASELINE  = 3'd2,
    REG_PRT_BASELINE  = 3'd3,
    REG_NEG_INV_WHITE = 3'd4,
    REG_PRT_INV_WHITE = 3'd5
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_D0, S_D1, S_D2, S_D3, S_E0, S_E1, S_E2,
    S_XM, S_XW, S_T0, S_T1, S_T2,
    S_F0, S_F1, S_F2, S_NORM, S_LM, S_LW, S_L2, S_L3, S_DONE
  } state_t;

  // One spectral entry as stored
  typedef struct packed {
    logic [15:0] base;
    logic [15:0] mz;
    logic [15:0] my;
    logic [15:0] mx;
    logic [15:0] ey;
    logic [15:0] em;
    logic [15:0] ec;
  } tbl_entry_t;

  typedef logic [30:0] rt_tab_t [EXP_BITS];

  // Integer square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r  = '0;
    b  = 64'd1 << 62;
    vv = v;
    for (int j = 0; j < 32; j++) begin
      if (b > vv) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (vv >= r + b) begin
          vv = vv - (r + b);
          r  = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Roots 2^(2^-i) in Q1.30 for i = 1..20
  function automatic rt_tab_t rt_build();
    rt_tab_t t;
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    t[0] = r[30:0];
    for (int c = 1; c < EXP_BITS; c++) begin
      r = isqrt64({33'd0, t[c-1]} << 30);
      t[c] = r[30:0];
    end
    return t;
  endfunction

  localparam rt_tab_t RT_TAB = rt_build();

endpackage

// ----- hdl/dtx_mul.sv -----
module dtx_mul (
  input  logic                                clk,
  input  logic signed [dtx_pkg::MUL_W-1:0]    a,
  input  logic signed [dtx_pkg::MUL_W-1:0]    b,
  output logic signed [2*dtx_pkg::MUL_W-1:0]  prod
);
  import dtx_pkg::*;

  // Registered signed product, shared by all multiplier steps of the sequencer
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- hdl/density_to_xyz_spectral.sv -----
// Spectral density to CIE XYZ. Load items (opcode 0/1) write one spectral entry.
// A convert item (opcode 2/3) runs on one shared 33x33 multiplier under a
// sequencer and keeps in_ready low until done: each of the K used entries takes
// an extra root-product step per set bit among the top 20 fraction bits of its
// exponent, then the three finishing passes follow (two product steps, a
// byte/bit normalize of the 96-bit sum, 20 squaring steps, the log10 scale).
// A bank with zero entries goes straight to the output register, where the
// result waits.
module density_to_xyz_spectral #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic               clk,
  input  logic               rst,
  // input item
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [6:0]         entry_index,
  input  logic [15:0]        eps_cyan,
  input  logic [15:0]        eps_magenta,
  input  logic [15:0]        eps_yellow,
  input  logic [15:0]        match_x,
  input  logic [15:0]        match_y,
  input  logic [15:0]        match_z,
  input  logic signed [15:0] base_density,
  input  logic signed [15:0] dens_cyan,
  input  logic signed [15:0] dens_magenta,
  input  logic signed [15:0] dens_yellow,
  // result item
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic signed [21:0] log_x,
  output logic signed [21:0] log_y,
  output logic signed [21:0] log_z,
  output logic [23:0]        lin_x,
  output logic [23:0]        lin_y,
  output logic [23:0]        lin_z,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dtx_pkg::*;

  localparam int AW = $clog2(2 * MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = 36;

  // configuration registers
  logic [7:0]  neg_entries, print_entries;
  logic        neg_has_baseline, print_has_baseline;
  logic [31:0] neg_inv_white_y, print_inv_white_y;
  logic        wr_en;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      neg_entries        <= '0;
      print_entries      <= '0;
      neg_has_baseline   <= 1'b0;
      print_has_baseline <= 1'b0;
      neg_inv_white_y    <= INV_WHITE_ONE;
      print_inv_white_y  <= INV_WHITE_ONE;
    end else if (wr_en) begin
      case (ridx)
        REG_NEG_ENTRIES:   neg_entries        <= pwdata[7:0];
        REG_PRT_ENTRIES:   print_entries      <= pwdata[7:0];
        REG_NEG_BASELINE:  neg_has_baseline   <= pwdata[0];
        REG_PRT_BASELINE:  print_has_baseline <= pwdata[0];
        REG_NEG_INV_WHITE: neg_inv_white_y    <= pwdata;
        REG_PRT_INV_WHITE: print_inv_white_y  <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (ridx)
      REG_NEG_ENTRIES:   prdata = {24'd0, neg_entries};
      REG_PRT_ENTRIES:   prdata = {24'd0, print_entries};
      REG_NEG_BASELINE:  prdata = {31'd0, neg_has_baseline};
      REG_PRT_BASELINE:  prdata = {31'd0, print_has_baseline};
      REG_NEG_INV_WHITE: prdata = neg_inv_white_y;
      REG_PRT_INV_WHITE: prdata = print_inv_white_y;
      default:           prdata = '0;
    endcase
  end

  // item state
  state_t state, state_next;
  logic        bank;
  logic        base_en;
  logic [31:0] inv_w;
  logic signed [15:0] dc, dm, dy;
  logic [CW-1:0] cnt, k_lim;
  logic [4:0]  bit_idx;
  logic [1:0]  ch;
  logic signed [DW-1:0] d;
  logic [63:0] e_lo;
  logic signed [63:0] e;
  logic [30:0] mant;
  logic [63:0] term;
  logic [63:0] acc [3];
  logic [63:0] lo;
  logic [95:0] v;
  logic [6:0]  p;
  logic [31:0] x;
  logic [LOG_BITS-1:0] frac;
  logic        ok_r;
  logic [23:0] lin_r [3];
  logic [21:0] log_r [3];

  // table memory
  tbl_entry_t mem [2 * MAX_ENTRIES];
  tbl_entry_t rd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic in_acc, is_load, load_ok;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign is_load  = (opcode == OP_LOAD_NEG) || (opcode == OP_LOAD_PRT);
  assign load_ok  = 32'(entry_index) < MAX_ENTRIES;
  assign wr_addr  = opcode[0] ? AW'(MAX_ENTRIES) + AW'(entry_index) : AW'(entry_index);
  assign rd_addr  = bank ? AW'(MAX_ENTRIES) + AW'(cnt) : AW'(cnt);

  always_ff @(posedge clk) begin
    if (in_acc && is_load && load_ok) begin
      mem[wr_addr] <= '{base: base_density, mz: match_z, my: match_y, mx: match_x,
                        ey: eps_yellow, em: eps_magenta, ec: eps_cyan};
    end
    if (state == S_RD) rd <= mem[rd_addr];
  end

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;

  dtx_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // helper values
  logic [7:0]  ent_sel;
  logic [CW-1:0] k_new;
  logic signed [13:0] kk;
  logic [5:0]  e_pos;
  logic [15:0] w_sel;
  logic last_entry;

  assign ent_sel    = opcode[0] ? print_entries : neg_entries;
  assign k_new      = (32'(ent_sel) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(ent_sel);
  assign kk         = e[63:50];
  assign e_pos      = 6'd50 - {1'b0, bit_idx};
  assign last_entry = (cnt == k_lim - CW'(1));

  always_comb begin
    case (ch)
      2'd0:    w_sel = rd.mx;
      2'd1:    w_sel = rd.my;
      default: w_sel = rd.mz;
    endcase
  end

  // sequencer: next state and multiplier operands
  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !is_load) state_next = (k_new == '0) ? S_DONE : S_RD;
      end
      S_RD: state_next = S_D0;
      S_D0: begin
        mul_a = MUL_W'(dc);
        mul_b = $signed({17'd0, rd.ec});
        state_next = S_D1;
      end
      S_D1: begin
        mul_a = MUL_W'(dm);
        mul_b = $signed({17'd0, rd.em});
        state_next = S_D2;
      end
      S_D2: begin
        mul_a = MUL_W'(dy);
        mul_b = $signed({17'd0, rd.ey});
        state_next = S_D3;
      end
      S_D3: state_next = S_E0;
      S_E0: begin
        mul_a = $signed({16'd0, d[16:0]});
        mul_b = $signed({7'd0, LOG2_10_Q24});
        state_next = S_E1;
      end
      S_E1: begin
        mul_a = MUL_W'($signed(d[DW-1:17]));
        mul_b = $signed({7'd0, LOG2_10_Q24});
        state_next = S_E2;
      end
      S_E2: state_next = S_XM;
      S_XM: begin
        mul_a = $signed({2'd0, mant});
        mul_b = $signed({2'd0, RT_TAB[bit_idx - 5'd1]});
        if (e[e_pos]) state_next = S_XW;
        else if (bit_idx == 5'(EXP_BITS)) state_next = S_T0;
      end
      S_XW: state_next = (bit_idx == 5'(EXP_BITS)) ? S_T0 : S_XM;
      S_T0: begin
        mul_a = $signed({2'd0, mant});
        mul_b = $signed({17'd0, w_sel});
        state_next = S_T1;
      end
      S_T1: state_next = S_T2;
      S_T2: begin
        if (ch == 2'd2) state_next = last_entry ? S_F0 : S_RD;
        else state_next = S_T0;
      end
      S_F0: begin
        mul_a = $signed({1'b0, acc[ch][31:0]});
        mul_b = $signed({1'b0, inv_w});
        state_next = S_F1;
      end
      S_F1: begin
        mul_a = $signed({1'b0, acc[ch][63:32]});
        mul_b = $signed({1'b0, inv_w});
        state_next = S_F2;
      end
      S_F2: state_next = S_NORM;
      S_NORM: if (v[95]) state_next = S_LM;
      S_LM: begin
        mul_a = $signed({1'b0, x});
        mul_b = $signed({1'b0, x});
        state_next = S_LW;
      end
      S_LW: state_next = (bit_idx == 5'(LOG_BITS)) ? S_L2 : S_LM;
      S_L2: begin
        mul_a = MUL_W'($signed({$signed({1'b0, p}) - 8'sd64, frac}));
        mul_b = $signed({2'd0, LOG10_2_Q32});
        state_next = S_L3;
      end
      S_L3: state_next = (ch == 2'd2) ? S_DONE : S_F0;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // term scaling by 2^(kk-4), truncating and saturating
  logic signed [15:0] sh;
  logic [63:0]  p64, term_next;
  logic [127:0] wide;
  always_comb begin
    p64  = {17'd0, prod[46:0]};
    sh   = 16'(kk) - 16'sd4;
    wide = {64'd0, p64} << sh[5:0];
    if (sh >= 16'sd64)       term_next = (p64 != '0) ? '1 : '0;
    else if (sh >= 16'sd0)   term_next = (wide[127:64] != '0) ? '1 : wide[63:0];
    else if (sh <= -16'sd64) term_next = '0;
    else                     term_next = p64 >> 6'(-sh);
  end

  // saturating accumulate
  logic [64:0] acc_sum;
  assign acc_sum = {1'b0, acc[ch]} + {1'b0, term};

  // finishing: high word, linear output and epsilon
  logic [63:0] rhi;
  logic [32:0] lo_eps;
  assign rhi    = prod[63:0] + {32'd0, lo[63:32]};
  assign lo_eps = {1'b0, lo[31:0]} + {1'b0, EPS_Q64};

  // log10 rounding and clamp
  logic [65:0] lmag, lrnd;
  logic signed [31:0] lres;
  always_comb begin
    lmag = prod[2*MUL_W-1] ? 66'(-prod) : 66'(prod);
    lrnd = (lmag + (66'd1 << 35)) >> 36;
    lres = prod[2*MUL_W-1] ? -$signed(lrnd[31:0]) : $signed(lrnd[31:0]);
    if (lres > 32'sd2097151)       lres = 32'sd2097151;
    else if (lres < -32'sd2097152) lres = -32'sd2097152;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid && !is_load) begin
          bank    <= opcode[0];
          base_en <= opcode[0] ? print_has_baseline : neg_has_baseline;
          inv_w   <= opcode[0] ? print_inv_white_y : neg_inv_white_y;
          dc      <= dens_cyan;
          dm      <= dens_magenta;
          dy      <= dens_yellow;
          k_lim   <= k_new;
          cnt     <= '0;
          ch      <= 2'd0;
          ok_r    <= (k_new != '0);
          for (int c = 0; c < 3; c++) begin
            acc[c]   <= '0;
            lin_r[c] <= '0;
            log_r[c] <= '0;
          end
        end
      end
      S_D1: begin
        d <= DW'($signed(prod[32:0])) +
             (base_en ? DW'($signed(rd.base)) <<< 14 : DW'(0));
      end
      S_D2, S_D3: d <= d + DW'($signed(prod[32:0]));
      S_E1: e_lo <= prod[63:0];
      S_E2: begin
        e       <= -((64'(prod) <<< 17) + $signed(e_lo));
        mant    <= 31'd1 << 30;
        bit_idx <= 5'd1;
      end
      S_XM: if (!e[e_pos]) bit_idx <= bit_idx + 5'd1;
      S_XW: begin
        mant    <= prod[60:30];
        bit_idx <= bit_idx + 5'd1;
      end
      S_T1: term <= term_next;
      S_T2: begin
        acc[ch] <= acc_sum[64] ? '1 : acc_sum[63:0];
        if (ch == 2'd2) begin
          ch  <= 2'd0;
          cnt <= cnt + CW'(1);
        end else begin
          ch <= ch + 2'd1;
        end
      end
      S_F1: lo <= prod[63:0];
      S_F2: begin
        lin_r[ch] <= (rhi[63:10] > 54'hFFFFFF) ? 24'hFFFFFF : rhi[33:10];
        v <= {rhi + {63'd0, lo_eps[32]}, lo_eps[31:0]};
        p <= 7'd95;
      end
      S_NORM: begin
        if (v[95:88] == 8'd0) begin
          v <= v << 8;
          p <= p - 7'd8;
        end else if (!v[95]) begin
          v <= v << 1;
          p <= p - 7'd1;
        end else begin
          x       <= v[95:64];
          frac    <= '0;
          bit_idx <= 5'd1;
        end
      end
      S_LW: begin
        frac    <= {frac[LOG_BITS-2:0], prod[63]};
        x       <= prod[63] ? prod[63:32] : prod[62:31];
        bit_idx <= bit_idx + 5'd1;
      end
      S_L3: begin
        log_r[ch] <= lres[21:0];
        ch        <= ch + 2'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      ok    <= ok_r;
      lin_x <= lin_r[0];
      lin_y <= lin_r[1];
      lin_z <= lin_r[2];
      log_x <= log_r[0];
      log_y <= log_r[1];
      log_z <= log_r[2];
    end
  end

  // a convert item holds off further items
  a_conv_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && opcode[1]) |=> !in_ready)
    else $error("input accepted during a convert");

  // squaring loop always starts from a normalized mantissa
  a_log_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_LM) |-> x[31])
    else $error("log mantissa not normalized");

  // an empty bank gives all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (lin_x == '0 && lin_y == '0 && lin_z == '0 &&
                            log_x == '0 && log_y == '0 && log_z == '0))
    else $error("empty bank result not zero");

endmodule

// ----- bench/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dtx_pkg::*;

  localparam int NENT = 128;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    opcode_t            op;
    logic [6:0]         idx;
    logic [15:0]        ec, em, ey, mx, my, mz;
    logic signed [15:0] base, dc, dm, dy;
  } pixel_item_t;

  typedef struct {
    logic        ok;
    logic [21:0] lgx, lgy, lgz;
    logic [23:0] lnx, lny, lnz;
  } xyz_result_t;

  typedef struct {
    logic [15:0] ec, em, ey, mx, my, mz, base;
  } spectral_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode = '0;
  logic [6:0]         entry_index = '0;
  logic [15:0]        eps_cyan = '0, eps_magenta = '0, eps_yellow = '0;
  logic [15:0]        match_x = '0, match_y = '0, match_z = '0;
  logic signed [15:0] base_density = '0, dens_cyan = '0, dens_magenta = '0;
  logic signed [15:0] dens_yellow = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               ok;
  logic signed [21:0] log_x, log_y, log_z;
  logic [23:0]        lin_x, lin_y, lin_z;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  density_to_xyz_spectral uut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the block's tables and registers
  spectral_entry_t   bank_tbl [2*NENT];
  logic [7:0]        n_entries [2];
  logic              use_base [2];
  logic [31:0]       inv_white [2];
  longint unsigned   exp_root [1:20];

  pixel_item_t pending_q [$];
  xyz_result_t xyz_expect_q [$];

  int  idle_pct = 0;
  int  stall_pct = 0;
  int  err_count = 0;
  int  quiet_cycles = 0;
  bit  in_fire = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Shift product by 2^s, truncating, saturating on overflow
  function automatic logic [63:0] shift_term(input logic [63:0] p, input longint s);
    if (p == 0) return 0;
    if (s >= 0) begin
      if (s >= 64 || p > (ONES64 >> s)) return ONES64;
      return p << s;
    end
    if (s <= -64) return 0;
    return p >> (-s);
  endfunction

  // White scaling, linear truncation and log10 of one channel
  function automatic void scale_and_log(input logic [63:0] acc, input logic [31:0] inv,
                                        output logic [23:0] lin, output logic [21:0] lg);
    logic [95:0]     v;
    logic [63:0]     m;
    longint unsigned x, sq, frac;
    longint          l2, prod, mag, res;
    int              p;
    v = {32'd0, acc} * {64'd0, inv};
    lin = (v[95:42] > 54'hFFFFFF) ? 24'hFFFFFF : v[65:42];
    v = v + {64'd0, EPS_Q64};
    p = 0;
    for (int j = 0; j < 96; j++) if (v[j]) p = j;
    if (p >= 63) m = 64'(v >> (p - 63));
    else m = v[63:0] << (63 - p);
    x = m >> 32;
    frac = 0;
    for (int j = 0; j < LOG_BITS; j++) begin
      sq = x * x;
      frac = frac << 1;
      if (sq[63]) begin
        frac = frac | 1;
        x = sq >> 32;
      end else begin
        x = sq >> 31;
      end
    end
    l2 = longint'(p - 64) * (longint'(1) << LOG_BITS) + longint'(frac);
    prod = l2 * longint'(LOG10_2_Q32);
    mag = prod < 0 ? -prod : prod;
    mag = (mag + (longint'(1) << 35)) >>> 36;
    res = prod < 0 ? -mag : mag;
    if (res > 2097151) res = 2097151;
    if (res < -2097152) res = -2097152;
    lg = res[21:0];
  endfunction

  // Integrate one pixel over its bank, or record a table load
  function automatic void integrate_pixel(input pixel_item_t it);
    int              bank, k, a;
    logic [63:0]     acc [3];
    logic [15:0]     w [3];
    longint          d, e, kk, f;
    longint unsigned mant;
    xyz_result_t     r;
    bank = it.op[0];
    if (it.op == OP_LOAD_NEG || it.op == OP_LOAD_PRT) begin
      a = bank * NENT + it.idx;
      bank_tbl[a] = '{it.ec, it.em, it.ey, it.mx, it.my, it.mz, it.base};
      return;
    end
    r = '{0, 0, 0, 0, 0, 0, 0};
    k = n_entries[bank];
    if (k > NENT) k = NENT;
    if (k != 0) begin
      acc = '{0, 0, 0};
      for (int i = 0; i < k; i++) begin
        a = bank * NENT + i;
        d = longint'(it.dc) * longint'(bank_tbl[a].ec) + longint'(it.dm) * longint'(bank_tbl[a].em)
          + longint'(it.dy) * longint'(bank_tbl[a].ey);
        if (use_base[bank]) d = d + longint'($signed(bank_tbl[a].base)) * 16384;
        e = -(d * longint'(LOG2_10_Q24));
        kk = e >>> 50;
        f = e - (kk <<< 50);
        mant = 64'd1 << 30;
        for (int c = 1; c <= EXP_BITS; c++)
          if (f[50-c]) mant = (mant * exp_root[c]) >> 30;
        w = '{bank_tbl[a].mx, bank_tbl[a].my, bank_tbl[a].mz};
        for (int c = 0; c < 3; c++) begin
          logic [63:0] t, s;
          t = shift_term(mant * w[c], kk - 4);
          s = acc[c] + t;
          acc[c] = (s < acc[c]) ? ONES64 : s;
        end
      end
      r.ok = 1;
      scale_and_log(acc[0], inv_white[bank], r.lnx, r.lgx);
      scale_and_log(acc[1], inv_white[bank], r.lny, r.lgy);
      scale_and_log(acc[2], inv_white[bank], r.lnz, r.lgz);
    end
    xyz_expect_q.push_back(r);
  endfunction

  // Input driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        pixel_item_t it;
        it = pending_q.pop_front();
        opcode <= it.op;
        entry_index <= it.idx;
        eps_cyan <= it.ec;
        eps_magenta <= it.em;
        eps_yellow <= it.ey;
        match_x <= it.mx;
        match_y <= it.my;
        match_z <= it.mz;
        base_density <= it.base;
        dens_cyan <= it.dc;
        dens_magenta <= it.dm;
        dens_yellow <= it.dy;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // Monitor: predict on accepted items, check accepted results, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      pixel_item_t it;
      bit out_fire;
      in_fire = in_valid && in_ready;
      out_fire = out_valid && out_ready;
      if (in_fire) begin
        it.op = opcode_t'(opcode);
        it.idx = entry_index;
        it.ec = eps_cyan;
        it.em = eps_magenta;
        it.ey = eps_yellow;
        it.mx = match_x;
        it.my = match_y;
        it.mz = match_z;
        it.base = base_density;
        it.dc = dens_cyan;
        it.dm = dens_magenta;
        it.dy = dens_yellow;
        integrate_pixel(it);
      end
      if (out_fire) begin
        if (xyz_expect_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          xyz_result_t w;
          w = xyz_expect_q.pop_front();
          if (ok !== w.ok) report("ok", ok, w.ok);
          if (log_x !== w.lgx) report("log_x", log_x, w.lgx);
          if (log_y !== w.lgy) report("log_y", log_y, w.lgy);
          if (log_z !== w.lgz) report("log_z", log_z, w.lgz);
          if (lin_x !== w.lnx) report("lin_x", lin_x, w.lnx);
          if (lin_y !== w.lny) report("lin_y", lin_y, w.lny);
          if (lin_z !== w.lnz) report("lin_z", lin_z, w.lnz);
        end
      end
      if (in_fire || out_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no progress for %0d cycles", quiet_cycles);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    case (r)
      REG_NEG_ENTRIES:   n_entries[0] = v[7:0];
      REG_PRT_ENTRIES:   n_entries[1] = v[7:0];
      REG_NEG_BASELINE:  use_base[0] = v[0];
      REG_PRT_BASELINE:  use_base[1] = v[0];
      REG_NEG_INV_WHITE: inv_white[0] = v;
      REG_PRT_INV_WHITE: inv_white[1] = v;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(r) << 2;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || xyz_expect_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_banks(input int nk, input int pk, input bit nb, input bit pb,
                           input logic [31:0] nw, input logic [31:0] pw);
    wait_drained();
    write_reg(REG_NEG_ENTRIES, nk);
    write_reg(REG_PRT_ENTRIES, pk);
    write_reg(REG_NEG_BASELINE, nb);
    write_reg(REG_PRT_BASELINE, pb);
    write_reg(REG_NEG_INV_WHITE, nw);
    write_reg(REG_PRT_INV_WHITE, pw);
  endtask

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1024));
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  function automatic logic [15:0] rand_density();
    case ($urandom_range(4))
      0: return 16'($urandom);
      1: return 16'(-$urandom_range(0, 8192));
      default: return 16'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  function automatic pixel_item_t load_item(input opcode_t op, input int idx);
    pixel_item_t it;
    it.op = op;
    it.idx = 7'(idx);
    it.ec = rand_weight();
    it.em = rand_weight();
    it.ey = rand_weight();
    it.mx = 16'($urandom);
    it.my = 16'($urandom);
    it.mz = 16'($urandom);
    it.base = rand_density();
    it.dc = 16'($urandom);
    it.dm = 16'($urandom);
    it.dy = 16'($urandom);
    return it;
  endfunction

  function automatic pixel_item_t pixel(input opcode_t op, input logic [15:0] c,
                                        input logic [15:0] m, input logic [15:0] y);
    pixel_item_t it;
    it = load_item(op, $urandom_range(127));
    it.dc = c;
    it.dm = m;
    it.dy = y;
    return it;
  endfunction

  task automatic random_phase(input int n, input int idl, input int stl);
    idle_pct = idl;
    stall_pct = stl;
    repeat (n) begin
      int sel;
      sel = $urandom_range(99);
      if (sel < 20)
        pending_q.push_back(load_item($urandom_range(1) ? OP_LOAD_PRT : OP_LOAD_NEG,
                                      $urandom_range(127)));
      else
        pending_q.push_back(pixel(sel[0] ? OP_CONV_PRT : OP_CONV_NEG,
                                  rand_density(), rand_density(), rand_density()));
    end
  endtask

  initial begin
    pixel_item_t it;
    exp_root[1] = int_sqrt(64'd1 << 61);
    for (int c = 2; c <= 20; c++) exp_root[c] = int_sqrt(exp_root[c-1] << 30);
    n_entries = '{0, 0};
    use_base = '{0, 0};
    inv_white = '{INV_WHITE_ONE, INV_WHITE_ONE};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty banks answer ok=0
    pending_q.push_back(pixel(OP_CONV_NEG, 0, 0, 0));
    pending_q.push_back(pixel(OP_CONV_PRT, 16'h7FFF, 16'h8000, 0));
    wait_drained();

    // Fill both banks; entry 0 all ones with highest baseline, entry 1 all zeros with lowest baseline
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < NENT; i++) begin
        it = load_item(b ? OP_LOAD_PRT : OP_LOAD_NEG, i);
        if (i == 0) begin
          {it.ec, it.em, it.ey, it.mx, it.my, it.mz} = {6{16'hFFFF}};
          it.base = 16'h7FFF;
        end else if (i == 1) begin
          {it.ec, it.em, it.ey, it.mx, it.my, it.mz} = '0;
          it.base = 16'h8000;
        end
        pending_q.push_back(it);
      end
    end

    // Density extremes: saturation, underflow, zero, mixed signs
    set_banks(1, 2, 1, 0, INV_WHITE_ONE, INV_WHITE_ONE);
    pending_q.push_back(pixel(OP_CONV_NEG, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_q.push_back(pixel(OP_CONV_NEG, 16'h8000, 16'h8000, 16'h8000));
    pending_q.push_back(pixel(OP_CONV_NEG, 0, 0, 0));
    pending_q.push_back(pixel(OP_CONV_PRT, 16'h8000, 16'h8000, 16'h8000));
    pending_q.push_back(pixel(OP_CONV_PRT, 0, 0, 0));
    pending_q.push_back(pixel(OP_CONV_PRT, 16'h1000, 16'hF000, 16'h0001));
    set_banks(2, 1, 0, 1, 32'hFFFF_FFFF, 32'd0);
    pending_q.push_back(pixel(OP_CONV_NEG, 16'h8000, 16'h8000, 16'h8000));
    pending_q.push_back(pixel(OP_CONV_NEG, 0, 0, 0));
    pending_q.push_back(pixel(OP_CONV_PRT, 16'hFFFF, 0, 16'h7FFF));

    set_banks(4, 3, 1, 0, INV_WHITE_ONE, INV_WHITE_ONE);
    random_phase(200, 0, 0);
    set_banks(1, 8, 0, 1, 32'h0200_0000, 32'h0080_0000);
    random_phase(200, 53, 0);
    set_banks(6, 2, 1, 1, 32'hFFFF_FFFF, 32'd0);
    random_phase(200, 0, 53);
    set_banks(3, 5, 0, 0, $urandom, $urandom);
    random_phase(200, 25, 25);
    // Full banks, few items
    set_banks(128, 128, 1, 1, INV_WHITE_ONE, $urandom);
    random_phase(12, 0, 0);
    set_banks(2, 4, 1, 0, $urandom, $urandom);
    random_phase(300, 25, 25);
    set_banks(5, 1, 0, 1, 32'h0001_0000, 32'h1000_0000);
    random_phase(300, 53, 53);
    set_banks(0, 7, 0, 1, INV_WHITE_ONE, $urandom);
    random_phase(120, 0, 0);

    wait_drained();
    repeat (50) @(negedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
